>>> hdl/assert_macros.svh
// assertion helpers used by the checker file pss_chk.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PSS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, disabled during reset
`define PSS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

>>> hdl/pss_pkg.sv
package pss_pkg;

  localparam int DEF_ACTIVE_SLOTS = 8;
  localparam int DEF_WAIT_DEPTH   = 16;
  localparam int DEF_ID_BITS      = 8;

  localparam int CMD_W     = 2;
  localparam int PRIO_W    = 2;
  localparam int STATUS_W  = 4;
  localparam int MAXACT_W  = 4;
  localparam int MAXWAIT_W = 5;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PROMOTE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd3;

  localparam logic [PRIO_W-1:0] PRIO_CANCEL = 2'd0;
  localparam logic [PRIO_W-1:0] PRIO_WAIT   = 2'd1;
  localparam logic [PRIO_W-1:0] PRIO_LOAD   = 2'd2;
  localparam logic [PRIO_W-1:0] PRIO_ALWAYS = 2'd3;

  localparam logic [STATUS_W-1:0] ST_ADMIT    = 4'd0;
  localparam logic [STATUS_W-1:0] ST_EVICT    = 4'd1;
  localparam logic [STATUS_W-1:0] ST_CANCEL   = 4'd2;
  localparam logic [STATUS_W-1:0] ST_QUEUED   = 4'd3;
  localparam logic [STATUS_W-1:0] ST_REJECT   = 4'd4;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 4'd5;
  localparam logic [STATUS_W-1:0] ST_PROMOTED = 4'd6;
  localparam logic [STATUS_W-1:0] ST_NONE     = 4'd7;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACTIVE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WAIT   = 1'b1;

  // result control fields, travel with the reported id
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                id_valid;
    logic                last;
  } res_ctl_t;

endpackage

>>> hdl/pss_ram.sv
module pss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                    rd_data,
  input  logic                                wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                    wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/pss_obuf.sv
module pss_obuf #(
  parameter int ID_BITS = pss_pkg::DEF_ID_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  pss_pkg::res_ctl_t             push_ctl,
  input  logic [ID_BITS-1:0]            push_id,
  output logic                          free,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pss_pkg::STATUS_W-1:0]  out_status,
  output logic [ID_BITS-1:0]            out_reported_id,
  output logic                          out_id_valid,
  output logic                          out_last
);

  logic              vld_r;
  pss_pkg::res_ctl_t ctl_r;
  logic [ID_BITS-1:0] id_r;

  assign free = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (free) begin
      vld_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && free) begin
      ctl_r <= push_ctl;
      id_r  <= push_id;
    end
  end

  assign out_valid       = vld_r;
  assign out_status      = ctl_r.status;
  assign out_reported_id = id_r;
  assign out_id_valid    = ctl_r.id_valid;
  assign out_last        = ctl_r.last;

endmodule

>>> hdl/pss_ctrl.sv
module pss_ctrl #(
  parameter int ACTIVE_SLOTS = pss_pkg::DEF_ACTIVE_SLOTS,
  parameter int WAIT_DEPTH   = pss_pkg::DEF_WAIT_DEPTH,
  parameter int ID_BITS      = pss_pkg::DEF_ID_BITS,
  localparam int AAW = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1,
  localparam int WAW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1,
  localparam int AEW = ID_BITS + pss_pkg::PRIO_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pss_pkg::CMD_W-1:0]     in_command,
  input  logic [ID_BITS-1:0]            in_task_id,
  input  logic [pss_pkg::PRIO_W-1:0]    in_priority_req,
  input  logic                          cfg_we,
  input  logic [pss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pss_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                          a_rd_en,
  output logic [AAW-1:0]                a_rd_addr,
  input  logic [AEW-1:0]                a_rd_data,
  output logic                          a_wr_en,
  output logic [AAW-1:0]                a_wr_addr,
  output logic [AEW-1:0]                a_wr_data,
  output logic                          w_rd_en,
  output logic [WAW-1:0]                w_rd_addr,
  input  logic [ID_BITS-1:0]            w_rd_data,
  output logic                          w_wr_en,
  output logic [WAW-1:0]                w_wr_addr,
  output logic [ID_BITS-1:0]            w_wr_data,
  input  logic                          obuf_free,
  output logic                          push,
  output pss_pkg::res_ctl_t             push_ctl,
  output logic [ID_BITS-1:0]            push_id
);

  localparam int CW  = $clog2(ACTIVE_SLOTS + 1);
  localparam int WCW = $clog2(WAIT_DEPTH + 1);
  localparam int MAW = (CW > pss_pkg::MAXACT_W) ? CW : pss_pkg::MAXACT_W;
  localparam int MWW = (WCW > pss_pkg::MAXWAIT_W) ? WCW : pss_pkg::MAXWAIT_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_FIND   = 7'b0000010,
    S_CMPCT  = 7'b0000100,
    S_PROM   = 7'b0001000,
    S_EMIT   = 7'b0010000,
    S_CLR_RD = 7'b0100000,
    S_CLR_EM = 7'b1000000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [pss_pkg::CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [ID_BITS-1:0]           id_r, id_nxt;
  logic [pss_pkg::PRIO_W-1:0]   prio_r, prio_nxt;
  logic [ID_BITS-1:0]           key_r, key_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [WAW-1:0]               whead_r, whead_nxt;
  logic [WCW-1:0]               wcnt_r, wcnt_nxt;
  logic [pss_pkg::MAXACT_W-1:0] max_act_r;
  logic [pss_pkg::MAXWAIT_W-1:0] max_wait_r;
  logic [CW-1:0]                rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]                wr_idx_r, wr_idx_nxt;
  logic                         pend_r, pend_nxt;
  logic [CW-1:0]                clr_n_r, clr_n_nxt;
  pss_pkg::res_ctl_t            res_ctl_r, res_ctl_nxt;
  logic [ID_BITS-1:0]           res_id_r, res_id_nxt;

  logic               act_room, wait_room;
  logic [WCW:0]       tail_sum;
  logic [WAW-1:0]     wtail;
  logic [WAW:0]       head_inc;
  logic [ID_BITS-1:0] rd_id;
  logic [pss_pkg::PRIO_W-1:0] rd_prio;
  logic               hit, issue, clr_last;

  assign rd_id   = a_rd_data[AEW-1:pss_pkg::PRIO_W];
  assign rd_prio = a_rd_data[pss_pkg::PRIO_W-1:0];

  // room checks against the register and the built size
  assign act_room  = (MAW'(cnt_r) < MAW'(max_act_r)) && (cnt_r < CW'(ACTIVE_SLOTS));
  assign wait_room = (MWW'(wcnt_r) < MWW'(max_wait_r)) && (wcnt_r < WCW'(WAIT_DEPTH));

  assign tail_sum = (WCW+1)'(whead_r) + (WCW+1)'(wcnt_r);
  assign wtail    = (tail_sum >= (WCW+1)'(WAIT_DEPTH)) ?
                    WAW'(tail_sum - (WCW+1)'(WAIT_DEPTH)) : WAW'(tail_sum);
  assign head_inc = (WAW+1)'(whead_r) + (WAW+1)'(1);

  assign clr_last = (rd_idx_r == CW'(clr_n_r - CW'(1)));
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    id_nxt      = id_r;
    prio_nxt    = prio_r;
    key_nxt     = key_r;
    cnt_nxt     = cnt_r;
    whead_nxt   = whead_r;
    wcnt_nxt    = wcnt_r;
    rd_idx_nxt  = rd_idx_r;
    wr_idx_nxt  = wr_idx_r;
    pend_nxt    = pend_r;
    clr_n_nxt   = clr_n_r;
    res_ctl_nxt = res_ctl_r;
    res_id_nxt  = res_id_r;
    a_rd_en     = 1'b0;
    a_rd_addr   = rd_idx_r[AAW-1:0];
    a_wr_en     = 1'b0;
    a_wr_addr   = wr_idx_r[AAW-1:0];
    a_wr_data   = a_rd_data;
    w_rd_en     = 1'b0;
    w_rd_addr   = whead_r;
    w_wr_en     = 1'b0;
    w_wr_addr   = wtail;
    w_wr_data   = in_task_id;
    push        = 1'b0;
    push_ctl    = res_ctl_r;
    push_id     = res_id_r;
    hit         = 1'b0;
    issue       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt              = in_command;
          id_nxt               = in_task_id;
          prio_nxt             = in_priority_req;
          res_ctl_nxt.id_valid = 1'b0;
          res_ctl_nxt.last     = 1'b1;
          res_id_nxt           = '0;
          rd_idx_nxt           = '0;
          wr_idx_nxt           = '0;
          pend_nxt             = 1'b0;
          state_nxt            = S_EMIT;
          unique case (in_command)
            pss_pkg::CMD_LOAD: begin
              if (act_room) begin
                a_wr_en            = 1'b1;
                a_wr_addr          = cnt_r[AAW-1:0];
                a_wr_data          = {in_task_id, in_priority_req};
                cnt_nxt            = cnt_r + CW'(1);
                res_ctl_nxt.status = pss_pkg::ST_ADMIT;
              end else begin
                case (in_priority_req)
                  pss_pkg::PRIO_CANCEL: res_ctl_nxt.status = pss_pkg::ST_CANCEL;
                  pss_pkg::PRIO_WAIT: begin
                    if (wait_room) begin
                      w_wr_en            = 1'b1;
                      wcnt_nxt           = wcnt_r + WCW'(1);
                      res_ctl_nxt.status = pss_pkg::ST_QUEUED;
                    end else begin
                      res_ctl_nxt.status = pss_pkg::ST_REJECT;
                    end
                  end
                  default: state_nxt = S_FIND;
                endcase
              end
            end
            pss_pkg::CMD_REMOVE: begin
              key_nxt   = in_task_id;
              state_nxt = S_CMPCT;
            end
            pss_pkg::CMD_PROMOTE: begin
              if (act_room && (wcnt_r != '0)) begin
                w_rd_en   = 1'b1;
                state_nxt = S_PROM;
              end else begin
                res_ctl_nxt.status = pss_pkg::ST_NONE;
              end
            end
            pss_pkg::CMD_CLEAR: begin
              clr_n_nxt          = cnt_r;
              cnt_nxt            = '0;
              whead_nxt          = '0;
              wcnt_nxt           = '0;
              res_ctl_nxt.status = pss_pkg::ST_CLEARED;
              if (cnt_r != '0) begin
                state_nxt = S_CLR_RD;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // pipelined scan for the first victim
      S_FIND: begin
        hit = pend_r && ((prio_r == pss_pkg::PRIO_LOAD) ? (rd_prio < prio_r)
                                                         : (rd_id != id_r));
        issue   = (rd_idx_r < cnt_r) && !hit;
        a_rd_en = issue;
        if (hit) begin
          key_nxt    = rd_id;
          rd_idx_nxt = '0;
          wr_idx_nxt = '0;
          pend_nxt   = 1'b0;
          state_nxt  = S_CMPCT;
        end else if (!issue && !pend_r) begin
          res_ctl_nxt.status = pss_pkg::ST_REJECT;
          state_nxt          = S_EMIT;
        end else begin
          pend_nxt   = issue;
          rd_idx_nxt = rd_idx_r + CW'(issue);
        end
      end

      // survivors are written back below the read pointer
      S_CMPCT: begin
        issue      = (rd_idx_r < cnt_r);
        a_rd_en    = issue;
        pend_nxt   = issue;
        rd_idx_nxt = rd_idx_r + CW'(issue);
        if (pend_r && (rd_id != key_r)) begin
          a_wr_en    = 1'b1;
          wr_idx_nxt = wr_idx_r + CW'(1);
        end
        if (!issue && !pend_r) begin
          state_nxt = S_EMIT;
          if (cmd_r == pss_pkg::CMD_LOAD) begin
            a_wr_en              = 1'b1;
            a_wr_data            = {id_r, prio_r};
            cnt_nxt              = wr_idx_r + CW'(1);
            res_ctl_nxt.status   = pss_pkg::ST_EVICT;
            res_ctl_nxt.id_valid = 1'b1;
            res_id_nxt           = key_r;
          end else begin
            cnt_nxt            = wr_idx_r;
            res_ctl_nxt.status = pss_pkg::ST_REMOVED;
          end
        end
      end

      S_PROM: begin
        a_wr_en              = 1'b1;
        a_wr_addr            = cnt_r[AAW-1:0];
        a_wr_data            = {w_rd_data, pss_pkg::PRIO_WAIT};
        cnt_nxt              = cnt_r + CW'(1);
        whead_nxt            = (head_inc == (WAW+1)'(WAIT_DEPTH)) ? '0 : head_inc[WAW-1:0];
        wcnt_nxt             = wcnt_r - WCW'(1);
        res_ctl_nxt.status   = pss_pkg::ST_PROMOTED;
        res_ctl_nxt.id_valid = 1'b1;
        res_id_nxt           = w_rd_data;
        state_nxt            = S_EMIT;
      end

      S_EMIT: begin
        if (obuf_free) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_CLR_RD: begin
        a_rd_en   = 1'b1;
        state_nxt = S_CLR_EM;
      end

      S_CLR_EM: begin
        push_ctl.status   = pss_pkg::ST_CLEARED;
        push_ctl.id_valid = 1'b1;
        push_ctl.last     = clr_last;
        push_id           = rd_id;
        if (obuf_free) begin
          push       = 1'b1;
          rd_idx_nxt = rd_idx_r + CW'(1);
          state_nxt  = clr_last ? S_IDLE : S_CLR_RD;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      whead_r    <= '0;
      wcnt_r     <= '0;
      pend_r     <= 1'b0;
      max_act_r  <= pss_pkg::MAXACT_W'(1);
      max_wait_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      whead_r <= whead_nxt;
      wcnt_r  <= wcnt_nxt;
      pend_r  <= pend_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          pss_pkg::CFG_MAX_ACTIVE: max_act_r  <= cfg_wdata[pss_pkg::MAXACT_W-1:0];
          pss_pkg::CFG_MAX_WAIT:   max_wait_r <= cfg_wdata[pss_pkg::MAXWAIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    id_r      <= id_nxt;
    prio_r    <= prio_nxt;
    key_r     <= key_nxt;
    rd_idx_r  <= rd_idx_nxt;
    wr_idx_r  <= wr_idx_nxt;
    clr_n_r   <= clr_n_nxt;
    res_ctl_r <= res_ctl_nxt;
    res_id_r  <= res_id_nxt;
  end

endmodule

>>> hdl/priority_slot_scheduler_unit.sv
// channel   direction  transfer when         payload
// in_       input      in_valid & in_ready   command, task_id, priority_req
// out_      output     out_valid & out_ready status, reported_id, id_valid, last
// cfg_      input      cfg_we                cfg_index, cfg_wdata
//
// load that fits, cancel, wait: decided, then emitted; promote: wait queue read, then
//   active list write, then emit; load with eviction: scan pass, then compaction pass
//   (each one slot read per cycle through the active list memory port), then emit
// remove: compaction pass; clear: read and emit per active entry, one result each
// reset is synchronous, active low; it empties both stores through their counts
// a stalled result holds in the output register; a new item is taken meanwhile
module priority_slot_scheduler_unit #(
  parameter int ACTIVE_SLOTS = pss_pkg::DEF_ACTIVE_SLOTS,
  parameter int WAIT_DEPTH   = pss_pkg::DEF_WAIT_DEPTH,
  parameter int ID_BITS      = pss_pkg::DEF_ID_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pss_pkg::CMD_W-1:0]     in_command,
  input  logic [ID_BITS-1:0]            in_task_id,
  input  logic [pss_pkg::PRIO_W-1:0]    in_priority_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pss_pkg::STATUS_W-1:0]  out_status,
  output logic [ID_BITS-1:0]            out_reported_id,
  output logic                          out_id_valid,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [pss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pss_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int AAW = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
  localparam int WAW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int AEW = ID_BITS + pss_pkg::PRIO_W;

  // active list memory: {id, priority} per slot, kept packed from slot 0
  logic           a_rd_en, a_wr_en;
  logic [AAW-1:0] a_rd_addr, a_wr_addr;
  logic [AEW-1:0] a_rd_data, a_wr_data;

  // waiting queue memory: ring of ids, head and count held in the sequencer
  logic               w_rd_en, w_wr_en;
  logic [WAW-1:0]     w_rd_addr, w_wr_addr;
  logic [ID_BITS-1:0] w_rd_data, w_wr_data;

  logic               obuf_free, push;
  pss_pkg::res_ctl_t  push_ctl;
  logic [ID_BITS-1:0] push_id;

  // the sequencer never reads and writes one slot in the same cycle:
  // compaction writes land below the read pointer, appends happen between passes
  pss_ctrl #(
    .ACTIVE_SLOTS (ACTIVE_SLOTS),
    .WAIT_DEPTH   (WAIT_DEPTH),
    .ID_BITS      (ID_BITS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_task_id      (in_task_id),
    .in_priority_req (in_priority_req),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .a_rd_en         (a_rd_en),
    .a_rd_addr       (a_rd_addr),
    .a_rd_data       (a_rd_data),
    .a_wr_en         (a_wr_en),
    .a_wr_addr       (a_wr_addr),
    .a_wr_data       (a_wr_data),
    .w_rd_en         (w_rd_en),
    .w_rd_addr       (w_rd_addr),
    .w_rd_data       (w_rd_data),
    .w_wr_en         (w_wr_en),
    .w_wr_addr       (w_wr_addr),
    .w_wr_data       (w_wr_data),
    .obuf_free       (obuf_free),
    .push            (push),
    .push_ctl        (push_ctl),
    .push_id         (push_id)
  );

  pss_ram #(
    .WIDTH (AEW),
    .DEPTH (ACTIVE_SLOTS)
  ) u_active_ram (
    .clk     (clk),
    .rd_en   (a_rd_en),
    .rd_addr (a_rd_addr),
    .rd_data (a_rd_data),
    .wr_en   (a_wr_en),
    .wr_addr (a_wr_addr),
    .wr_data (a_wr_data)
  );

  pss_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (WAIT_DEPTH)
  ) u_wait_ram (
    .clk     (clk),
    .rd_en   (w_rd_en),
    .rd_addr (w_rd_addr),
    .rd_data (w_rd_data),
    .wr_en   (w_wr_en),
    .wr_addr (w_wr_addr),
    .wr_data (w_wr_data)
  );

  // output register decouples result stalls from the sequencer
  pss_obuf #(
    .ID_BITS (ID_BITS)
  ) u_obuf (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .push_ctl        (push_ctl),
    .push_id         (push_id),
    .free            (obuf_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_reported_id (out_reported_id),
    .out_id_valid    (out_id_valid),
    .out_last        (out_last)
  );

endmodule

>>> hdl/pss_chk.sv
`include "assert_macros.svh"

module pss_chk #(
  parameter int ID_BITS = pss_pkg::DEF_ID_BITS
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [pss_pkg::STATUS_W-1:0] out_status,
  input logic [ID_BITS-1:0]           out_reported_id,
  input logic                         out_id_valid,
  input logic                         out_last
);

  logic [pss_pkg::STATUS_W+ID_BITS+1:0] out_pay;
  logic                                 clr_id;

  assign out_pay = {out_status, out_reported_id, out_id_valid, out_last};
  assign clr_id  = (out_status == pss_pkg::ST_CLEARED) && out_id_valid;

  // stalled result holds
  `PSS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_pay))

  // no id carried means a zero id field
  `PSS_ASSERT_IMP(a_id_zero, clk, rst_n, out_valid && !out_id_valid, out_reported_id == '0)

  // only clear yields more than one result, each with an id
  `PSS_ASSERT_IMP(a_multi_clear, clk, rst_n, out_valid && !out_last, clr_id)

  // one item at a time: a taken item closes the input until it is done
  `PSS_ASSERT_NXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)

  // status codes stay within the defined set
  `PSS_ASSERT_IMP(a_status_range, clk, rst_n, out_valid, out_status <= pss_pkg::ST_CLEARED)

endmodule

bind priority_slot_scheduler_unit pss_chk #(.ID_BITS(ID_BITS)) u_pss_chk (.*);

>>> verif/priority_slot_scheduler_unit_tb.sv
`timescale 1ns / 1ps

module priority_slot_scheduler_unit_tb;

  localparam int SLOTS      = pss_pkg::DEF_ACTIVE_SLOTS;
  localparam int QDEPTH     = pss_pkg::DEF_WAIT_DEPTH;
  localparam int ID_W       = pss_pkg::DEF_ID_BITS;
  localparam int IDLE_PCT   = 27;
  localparam int SETTLE_CYC = 40;    // longest busy pass (eviction scan plus compaction) and margin
  localparam int STALL_LIMIT = 3000; // cycles without any transfer before giving up

  // one scheduler command as driven on the input channel
  typedef struct {
    logic [pss_pkg::CMD_W-1:0]  command;
    logic [ID_W-1:0]            task_id;
    logic [pss_pkg::PRIO_W-1:0] priority_req;
  } sched_cmd_t;

  // one scheduler response as seen on the result channel
  typedef struct {
    logic [pss_pkg::STATUS_W-1:0] status;
    logic [ID_W-1:0]              reported_id;
    logic                         id_valid;
    logic                         last;
  } sched_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [pss_pkg::CMD_W-1:0]     in_command = pss_pkg::CMD_LOAD;
  logic [ID_W-1:0]               in_task_id = '0;
  logic [pss_pkg::PRIO_W-1:0]    in_priority_req = pss_pkg::PRIO_CANCEL;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [pss_pkg::STATUS_W-1:0]  out_status;
  logic [ID_W-1:0]               out_reported_id;
  logic                          out_id_valid;
  logic                          out_last;
  logic                          cfg_we = 1'b0;
  logic [pss_pkg::CFG_IDX_W-1:0] cfg_index = pss_pkg::CFG_MAX_ACTIVE;
  logic [pss_pkg::CFG_W-1:0]     cfg_wdata = '0;

  priority_slot_scheduler_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_task_id      (in_task_id),
    .in_priority_req (in_priority_req),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_reported_id (out_reported_id),
    .out_id_valid    (out_id_valid),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // commands waiting to be driven, responses waiting to arrive
  sched_cmd_t  cmd_backlog[$];
  sched_resp_t pending_resp[$];
  sched_cmd_t  drv_cmd;

  int  err_count = 0;
  bit  calm = 1'b0;            // set for the stretch with no idling on either side
  logic [ID_W-1:0] id_pool[8]; // small id set so removes and repeats actually hit

  // shadow of the scheduler state and its two limit registers
  logic [ID_W-1:0]            act_ids[SLOTS];
  logic [pss_pkg::PRIO_W-1:0] act_prio[SLOTS];
  int                         act_cnt = 0;
  logic [ID_W-1:0]            wq_ids[QDEPTH];
  int                         wq_head = 0;
  int                         wq_cnt = 0;
  logic [pss_pkg::MAXACT_W-1:0]  lim_active = 4'd1;
  logic [pss_pkg::MAXWAIT_W-1:0] lim_wait = 5'd0;

  function automatic void add_resp(logic [pss_pkg::STATUS_W-1:0] st, logic [ID_W-1:0] id,
                                   logic idv, logic lst);
    sched_resp_t r;
    r.status      = st;
    r.reported_id = idv ? id : '0;
    r.id_valid    = idv;
    r.last        = lst;
    pending_resp.insert(pending_resp.size(), r);
  endfunction

  // drop every copy of an id, survivors keep their order
  function automatic void drop_task(logic [ID_W-1:0] id);
    int w;
    w = 0;
    for (int r = 0; r < act_cnt; r++) begin
      if (act_ids[r] != id) begin
        act_ids[w]  = act_ids[r];
        act_prio[w] = act_prio[r];
        w++;
      end
    end
    act_cnt = w;
  endfunction

  function automatic void add_task(logic [ID_W-1:0] id, logic [pss_pkg::PRIO_W-1:0] prio);
    if (act_cnt < SLOTS) begin
      act_ids[act_cnt]  = id;
      act_prio[act_cnt] = prio;
      act_cnt++;
    end
  endfunction

  // advance the shadow state by one accepted command and queue its responses
  function automatic void schedule_outcomes(sched_cmd_t c);
    int cap_act;
    int cap_wait;
    int n;
    bit found;
    logic [ID_W-1:0] victim;
    cap_act  = (lim_active > SLOTS) ? SLOTS : lim_active;
    cap_wait = (lim_wait > QDEPTH) ? QDEPTH : lim_wait;
    found    = 1'b0;
    victim   = '0;
    case (c.command)
      pss_pkg::CMD_LOAD: begin
        if (act_cnt < cap_act) begin
          add_task(c.task_id, c.priority_req);
          add_resp(pss_pkg::ST_ADMIT, '0, 1'b0, 1'b1);
        end else if (c.priority_req == pss_pkg::PRIO_CANCEL) begin
          add_resp(pss_pkg::ST_CANCEL, '0, 1'b0, 1'b1);
        end else if (c.priority_req == pss_pkg::PRIO_WAIT) begin
          if (wq_cnt < cap_wait) begin
            wq_ids[(wq_head + wq_cnt) % QDEPTH] = c.task_id;
            wq_cnt++;
            add_resp(pss_pkg::ST_QUEUED, '0, 1'b0, 1'b1);
          end else begin
            add_resp(pss_pkg::ST_REJECT, '0, 1'b0, 1'b1);
          end
        end else begin
          // load evicts the first lower priority, load-always the first other id
          for (int i = 0; i < act_cnt; i++) begin
            if (!found && ((c.priority_req == pss_pkg::PRIO_LOAD) ?
                           (act_prio[i] < c.priority_req) : (act_ids[i] != c.task_id))) begin
              victim = act_ids[i];
              found  = 1'b1;
            end
          end
          if (found) begin
            drop_task(victim);
            add_task(c.task_id, c.priority_req);
            add_resp(pss_pkg::ST_EVICT, victim, 1'b1, 1'b1);
          end else begin
            add_resp(pss_pkg::ST_REJECT, '0, 1'b0, 1'b1);
          end
        end
      end
      pss_pkg::CMD_REMOVE: begin
        drop_task(c.task_id);
        add_resp(pss_pkg::ST_REMOVED, '0, 1'b0, 1'b1);
      end
      pss_pkg::CMD_PROMOTE: begin
        if (act_cnt < cap_act && wq_cnt > 0) begin
          victim  = wq_ids[wq_head];
          wq_head = (wq_head + 1) % QDEPTH;
          wq_cnt--;
          add_task(victim, pss_pkg::PRIO_WAIT);
          add_resp(pss_pkg::ST_PROMOTED, victim, 1'b1, 1'b1);
        end else begin
          add_resp(pss_pkg::ST_NONE, '0, 1'b0, 1'b1);
        end
      end
      default: begin
        n       = act_cnt;
        act_cnt = 0;
        wq_head = 0;
        wq_cnt  = 0;
        if (n == 0) begin
          add_resp(pss_pkg::ST_CLEARED, '0, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) begin
            add_resp(pss_pkg::ST_CLEARED, act_ids[i], 1'b1, i == n - 1);
          end
        end
      end
    endcase
  endfunction

  // driver: holds a command until its transfer, idles at random otherwise
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (cmd_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        drv_cmd = cmd_backlog[0];
        cmd_backlog.delete(0);
        in_valid        <= 1'b1;
        in_command      <= drv_cmd.command;
        in_task_id      <= drv_cmd.task_id;
        in_priority_req <= drv_cmd.priority_req;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // monitor: check the result transfer first, then predict from the input transfer
  always @(posedge clk) begin
    sched_resp_t exp_r;
    sched_cmd_t  acc_c;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_resp.size() == 0) begin
          $display("%0t unexpected result: expected none, actual status %0d id %0h id_valid %0b last %0b",
                   $time, out_status, out_reported_id, out_id_valid, out_last);
          err_count++;
        end else begin
          exp_r = pending_resp[0];
          pending_resp.delete(0);
          if (out_status !== exp_r.status) begin
            $display("%0t status mismatch: expected %0d actual %0d",
                     $time, exp_r.status, out_status);
            err_count++;
          end
          if (out_reported_id !== exp_r.reported_id) begin
            $display("%0t reported_id mismatch: expected %0h actual %0h",
                     $time, exp_r.reported_id, out_reported_id);
            err_count++;
          end
          if (out_id_valid !== exp_r.id_valid) begin
            $display("%0t id_valid mismatch: expected %0b actual %0b",
                     $time, exp_r.id_valid, out_id_valid);
            err_count++;
          end
          if (out_last !== exp_r.last) begin
            $display("%0t last mismatch: expected %0b actual %0b",
                     $time, exp_r.last, out_last);
            err_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        acc_c.command      = in_command;
        acc_c.task_id      = in_task_id;
        acc_c.priority_req = in_priority_req;
        schedule_outcomes(acc_c);
      end
    end
  end

  // watchdog: too long without any transfer on either channel
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t watchdog: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_cmd(logic [pss_pkg::CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                           logic [pss_pkg::PRIO_W-1:0] prio);
    sched_cmd_t c;
    c.command      = cmd;
    c.task_id      = id;
    c.priority_req = prio;
    cmd_backlog.insert(cmd_backlog.size(), c);
  endtask

  // register write, only while the block is idle
  task automatic write_reg(logic [pss_pkg::CFG_IDX_W-1:0] idx, logic [pss_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == pss_pkg::CFG_MAX_ACTIVE) lim_active = val[pss_pkg::MAXACT_W-1:0];
    else lim_wait = val[pss_pkg::MAXWAIT_W-1:0];
  endtask

  // all commands transferred and every response back, then let the block settle
  task automatic drain();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid || pending_resp.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // mostly loads from the pool, some removes, promotes, rare clears, some wild ids
  task automatic queue_random(int count);
    int r;
    logic [ID_W-1:0] id;
    for (int k = 0; k < count; k++) begin
      id = ($urandom_range(0, 99) < 70) ? id_pool[$urandom_range(0, 7)]
                                        : ID_W'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 55) queue_cmd(pss_pkg::CMD_LOAD, id, pss_pkg::PRIO_W'($urandom_range(0, 3)));
      else if (r < 70) queue_cmd(pss_pkg::CMD_REMOVE, id, pss_pkg::PRIO_W'($urandom_range(0, 3)));
      else if (r < 92) queue_cmd(pss_pkg::CMD_PROMOTE, id, pss_pkg::PRIO_W'($urandom_range(0, 3)));
      else queue_cmd(pss_pkg::CMD_CLEAR, id, pss_pkg::PRIO_W'($urandom_range(0, 3)));
    end
  endtask

  task automatic run_phase(logic [pss_pkg::CFG_W-1:0] act_val, logic [pss_pkg::CFG_W-1:0] wait_val,
                           bit no_idle, int count);
    write_reg(pss_pkg::CFG_MAX_ACTIVE, act_val);
    write_reg(pss_pkg::CFG_MAX_WAIT, wait_val);
    for (int i = 0; i < 8; i++) id_pool[i] = ID_W'($urandom_range(0, 255));
    @(negedge clk);
    calm = no_idle;
    queue_random(count);
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset limits: one slot, no waiting room
    queue_cmd(pss_pkg::CMD_CLEAR, 8'h00, pss_pkg::PRIO_CANCEL);    // clear with an empty list
    queue_cmd(pss_pkg::CMD_LOAD, 8'h00, pss_pkg::PRIO_CANCEL);     // admitted
    queue_cmd(pss_pkg::CMD_LOAD, 8'hFF, pss_pkg::PRIO_CANCEL);     // full, cancel class
    queue_cmd(pss_pkg::CMD_LOAD, 8'hFF, pss_pkg::PRIO_WAIT);       // no waiting room, rejected
    queue_cmd(pss_pkg::CMD_LOAD, 8'hAA, pss_pkg::PRIO_ALWAYS);     // evicts the other id
    queue_cmd(pss_pkg::CMD_LOAD, 8'hAA, pss_pkg::PRIO_ALWAYS);     // only itself left, rejected
    queue_cmd(pss_pkg::CMD_PROMOTE, 8'h00, pss_pkg::PRIO_ALWAYS);  // nothing waiting
    drain();

    write_reg(pss_pkg::CFG_MAX_ACTIVE, 5'd4);
    write_reg(pss_pkg::CFG_MAX_WAIT, 5'd2);
    @(negedge clk);
    queue_cmd(pss_pkg::CMD_LOAD, 8'h55, pss_pkg::PRIO_LOAD);
    queue_cmd(pss_pkg::CMD_LOAD, 8'h55, pss_pkg::PRIO_CANCEL);     // repeated id in the list
    queue_cmd(pss_pkg::CMD_LOAD, 8'h11, pss_pkg::PRIO_WAIT);       // list now full
    queue_cmd(pss_pkg::CMD_LOAD, 8'h22, pss_pkg::PRIO_WAIT);       // queued
    queue_cmd(pss_pkg::CMD_LOAD, 8'h33, pss_pkg::PRIO_WAIT);       // queued
    queue_cmd(pss_pkg::CMD_LOAD, 8'h44, pss_pkg::PRIO_WAIT);       // waiting queue full, rejected
    queue_cmd(pss_pkg::CMD_LOAD, 8'h66, pss_pkg::PRIO_LOAD);       // evicts a repeated id
    queue_cmd(pss_pkg::CMD_PROMOTE, 8'hFF, pss_pkg::PRIO_CANCEL);  // fills the space
    queue_cmd(pss_pkg::CMD_PROMOTE, 8'h00, pss_pkg::PRIO_WAIT);    // full, none promoted
    queue_cmd(pss_pkg::CMD_REMOVE, 8'hAA, pss_pkg::PRIO_LOAD);
    queue_cmd(pss_pkg::CMD_PROMOTE, 8'h00, pss_pkg::PRIO_CANCEL);
    queue_cmd(pss_pkg::CMD_LOAD, 8'h77, pss_pkg::PRIO_ALWAYS);
    queue_cmd(pss_pkg::CMD_LOAD, 8'h88, pss_pkg::PRIO_LOAD);       // evicts the first lower-priority id
    queue_cmd(pss_pkg::CMD_CLEAR, 8'hFF, pss_pkg::PRIO_ALWAYS);    // one result per active id
    queue_cmd(pss_pkg::CMD_REMOVE, 8'h00, pss_pkg::PRIO_CANCEL);   // remove on an empty list
    drain();

    // random phases; no clear in between so a lowered limit sits below the count
    run_phase(5'd8, 5'd16, 1'b0, 50);
    run_phase(5'd2, 5'd1, 1'b0, 30);
    run_phase(5'd15, 5'd31, 1'b1, 50);   // above built size, saturates; no idling
    run_phase(5'd0, 5'd5, 1'b0, 25);     // zero slots, list always full
    run_phase(5'd6, 5'd3, 1'b0, 30);
    run_phase(pss_pkg::CFG_W'($urandom_range(0, 31)), pss_pkg::CFG_W'($urandom_range(0, 31)),
              1'b0, 40);
    run_phase(5'd1, 5'd0, 1'b0, 23);

    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> priority_slot_scheduler_unit.f
+incdir+hdl
hdl/pss_pkg.sv
hdl/pss_ram.sv
hdl/pss_obuf.sv
hdl/pss_ctrl.sv
hdl/priority_slot_scheduler_unit.sv
hdl/pss_chk.sv
verif/priority_slot_scheduler_unit_tb.sv
